FILE: hw/rtl/bezier_segment_eval_3d_assert.svh
`ifndef BEZIER_SEGMENT_EVAL_3D_ASSERT_SVH
`define BEZIER_SEGMENT_EVAL_3D_ASSERT_SVH

// Same-cycle implication, sampled on clock and quiet while reset is high.
`define BSE_ASSERT_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and quiet while reset is high.
`define BSE_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/bse_pkg.sv
package bse_pkg;

   localparam int NUM_AXES = 3;
   localparam int SEG_W = 6;
   localparam int BINOM_W = 13;
   localparam int ROW_IDX_W = 4;
   localparam int ACC_W = 38;

   localparam logic [16:0] ONE_Q16 = 17'h10000;
   localparam logic [33:0] HALF_Q16 = 34'h8000;
   localparam logic [44:0] ONE_Q30 = 45'h4000_0000;

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_EVAL = 1'b1;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef logic [15:0][15:0] binom_row_type;

   // Tag that travels with each control point through the accumulate pipeline.
   typedef struct packed {
      logic       vld;
      logic       first;
      logic       last;
      logic [1:0] axis;
   } mac_tag_type;

   // Row n of Pascal's triangle, built by additions only.
   function automatic binom_row_type binom_row(input int n);
      binom_row_type row;
      row = '0;
      row[0] = 16'd1;
      for (int i = 1; i <= n; i++) begin
         for (int k = i; k >= 1; k--) begin
            row[k] = row[k] + row[k-1];
         end
      end
      return row;
   endfunction

endpackage

FILE: hw/rtl/bezier_segment_eval_3d.sv
// Bezier segment evaluator with a control point store. A request with
// req_action low writes one signed Q16.16 control point into the store in the
// cycle it is taken and never raises busy. A request with req_action high
// evaluates segment req_segment at t = req_t_frac (unsigned Q0.16) and
// returns x, y and z as saturated Q16.16 values. A request is taken at a
// rising edge where start is high and busy is low. The result is shown on the
// rsp_pos ports for exactly one cycle with rsp_valid high; the receiver cannot
// stall it, so it must capture the result in that cycle. An evaluation runs
// power generation on a pair of shared multipliers, then Bernstein weight
// generation, then one pass per axis in which the single multiply-accumulate
// unit takes one control point per cycle from the one-port store, and then
// waits for the store read and accumulate pipeline to empty. Busy falls in
// the cycle the result is shown, so the next request may be taken there. An
// evaluation of a segment at or beyond MAX_SEGMENTS returns zeros on the
// following cycle without raising busy. Writes to axis three, to a point
// index above ORDER or to a segment beyond the store are dropped. Reading a
// control point that was never written yields an unknown coordinate for
// that axis. The store is only written while the block is idle and only
// read while it is busy, so the two never meet on one entry.

`include "bezier_segment_eval_3d_assert.svh"

module bezier_segment_eval_3d
   import bse_pkg::*;
#(
   parameter int ORDER = 7,
   parameter int MAX_SEGMENTS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_action,
   input  logic [5:0]         req_segment,
   input  logic [1:0]         req_axis,
   input  logic [3:0]         req_point_index,
   input  logic signed [31:0] req_point_value,
   input  logic [15:0]        req_t_frac,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_pos_z
);

   localparam int NPTS = ORDER + 1;
   localparam int STRIDE = NUM_AXES * NPTS;
   localparam int DEPTH = MAX_SEGMENTS * STRIDE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int IDX_W = $clog2(NPTS);
   localparam int WIDE_W = ADDR_W + SEG_W;

   localparam binom_row_type BINOM = binom_row(ORDER);

   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh7FFF_FFFF);
   localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;
   localparam logic signed [63:0] RND_HALF = 64'sh2000_0000;

   // Sequencer codes.
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_POW   = 3'd1;
   localparam logic [2:0] ST_WGT   = 3'd2;
   localparam logic [2:0] ST_MAC   = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;

   // Request decode.
   logic              accept;
   logic              seg_ok;
   logic              wr_ok;
   logic              mem_we;
   logic              eval_go;
   logic              eval_bad;
   logic [WIDE_W-1:0] seg_base_wide;
   logic [WIDE_W-1:0] wr_addr_wide;

   // Sequencer.
   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       axis_ff, axis_in;
   logic             cnt_end;

   // Evaluation operands.
   logic [ADDR_W-1:0] base_ff;
   logic [15:0]       t_ff;
   logic [16:0]       u_ff;
   logic [16:0]       tcur_ff, ucur_ff;
   logic [33:0]       tprod, uprod;
   logic [16:0]       tnext, unext;
   logic [16:0]       tp_ff [NPTS];
   logic [16:0]       up_ff [NPTS];
   logic [IDX_W-1:0]  ord_minus_j;

   // Weight pipeline.
   logic             wp_vld_ff;
   logic [IDX_W-1:0] wp_j_ff;
   logic [33:0]      wp_ff;
   logic [46:0]      raw;
   logic [44:0]      wq;
   logic [30:0]      wnext;
   logic [30:0]      wgt_ff [NPTS];

   // Store and accumulate pipeline.
   logic [31:0]              cp_mem [DEPTH];
   logic [ADDR_W-1:0]        rd_addr;
   logic [31:0]              rd_data_ff;
   mac_tag_type              s1_tag_ff, s1_tag_in;
   mac_tag_type              s2_tag_ff;
   logic [IDX_W-1:0]         s1_j_ff;
   logic signed [63:0]       prod_ff;
   logic signed [63:0]       rnd;
   logic signed [ACC_W-1:0]  term;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [31:0]       sat;
   logic                     done;

   // Result registers.
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] pos_x_ff, pos_y_ff, pos_z_ff;

   // ------------------------------------------------------------------
   // Request decode. Address of a point: (segment*3 + axis)*(ORDER+1) + index.
   // ------------------------------------------------------------------
   assign accept = start && (state_ff == ST_IDLE);
   assign seg_ok = (int'(req_segment) < MAX_SEGMENTS);
   assign wr_ok = seg_ok && (req_axis <= AXIS_Z) && (int'(req_point_index) <= ORDER);
   assign mem_we = accept && (req_action == ACT_WRITE) && wr_ok;
   assign eval_go = accept && (req_action == ACT_EVAL) && seg_ok;
   assign eval_bad = accept && (req_action == ACT_EVAL) && !seg_ok;

   assign seg_base_wide = WIDE_W'(req_segment) * WIDE_W'(STRIDE);
   assign wr_addr_wide = seg_base_wide + WIDE_W'(req_axis) * WIDE_W'(NPTS)
                         + WIDE_W'(req_point_index);

   // ------------------------------------------------------------------
   // Sequencer: powers, then weights, then three passes over the store.
   // ------------------------------------------------------------------
   assign cnt_end = (cnt_ff == IDX_W'(ORDER));

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      axis_in = axis_ff;
      case (state_ff)
         ST_IDLE: begin
            if (eval_go) begin
               state_in = ST_POW;
               cnt_in = IDX_W'(1);
               axis_in = AXIS_X;
            end
         end
         ST_POW: begin
            if (cnt_end) begin
               state_in = ST_WGT;
               cnt_in = '0;
            end else begin
               cnt_in = cnt_ff + IDX_W'(1);
            end
         end
         ST_WGT: begin
            if (cnt_end) begin
               state_in = ST_MAC;
               cnt_in = '0;
               axis_in = AXIS_X;
            end else begin
               cnt_in = cnt_ff + IDX_W'(1);
            end
         end
         ST_MAC: begin
            if (cnt_end) begin
               cnt_in = '0;
               if (axis_ff == AXIS_Z) begin
                  state_in = ST_DRAIN;
               end else begin
                  axis_in = axis_ff + 2'd1;
               end
            end else begin
               cnt_in = cnt_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            if (done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      axis_ff <= axis_in;
   end

   // ------------------------------------------------------------------
   // Powers of t and of 1-t, one step of each per cycle, rounded to Q1.16.
   // ------------------------------------------------------------------
   assign tprod = 34'(tcur_ff) * 34'(t_ff) + HALF_Q16;
   assign uprod = 34'(ucur_ff) * 34'(u_ff) + HALF_Q16;
   assign tnext = tprod[32:16];
   assign unext = uprod[32:16];

   always_ff @(posedge clock) begin
      if (eval_go) begin
         t_ff <= req_t_frac;
         u_ff <= ONE_Q16 - 17'(req_t_frac);
         tcur_ff <= ONE_Q16;
         ucur_ff <= ONE_Q16;
         tp_ff[0] <= ONE_Q16;
         up_ff[0] <= ONE_Q16;
         base_ff <= seg_base_wide[ADDR_W-1:0];
      end
      if (state_ff == ST_POW) begin
         tcur_ff <= tnext;
         ucur_ff <= unext;
         tp_ff[cnt_ff] <= tnext;
         up_ff[cnt_ff] <= unext;
      end
   end

   // ------------------------------------------------------------------
   // Bernstein weights: t^j * (1-t)^(ORDER-j) is registered first; the binomial
   // factor, rounding and the clamp to one (Q1.30) follow in the cycle after.
   // ------------------------------------------------------------------
   assign ord_minus_j = IDX_W'(ORDER) - cnt_ff;
   assign raw = 47'(BINOM[ROW_IDX_W'(wp_j_ff)][BINOM_W-1:0]) * 47'(wp_ff) + 47'd2;
   assign wq = raw[46:2];
   assign wnext = (wq > ONE_Q30) ? ONE_Q30[30:0] : wq[30:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_vld_ff <= 1'b0;
      end else begin
         wp_vld_ff <= (state_ff == ST_WGT);
      end
   end

   always_ff @(posedge clock) begin
      wp_ff <= 34'(tp_ff[cnt_ff]) * 34'(up_ff[ord_minus_j]);
      wp_j_ff <= cnt_ff;
      if (wp_vld_ff) begin
         wgt_ff[wp_j_ff] <= wnext;
      end
   end

   // ------------------------------------------------------------------
   // Control point store: written by write requests while idle, read one
   // point per cycle during the accumulate passes.
   // ------------------------------------------------------------------
   assign rd_addr = base_ff + ADDR_W'(axis_ff) * ADDR_W'(NPTS) + ADDR_W'(cnt_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cp_mem[wr_addr_wide[ADDR_W-1:0]] <= req_point_value;
      end
      if (state_ff == ST_MAC) begin
         rd_data_ff <= cp_mem[rd_addr];
      end
   end

   // ------------------------------------------------------------------
   // Accumulate pipeline: store read, product, rounded accumulate.
   // ------------------------------------------------------------------
   always_comb begin
      s1_tag_in.vld = (state_ff == ST_MAC);
      s1_tag_in.first = (cnt_ff == '0);
      s1_tag_in.last = cnt_end;
      s1_tag_in.axis = axis_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff <= '0;
         s2_tag_ff <= '0;
      end else begin
         s1_tag_ff <= s1_tag_in;
         s2_tag_ff <= s1_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_j_ff <= cnt_ff;
      prod_ff <= $signed(rd_data_ff) * $signed({1'b0, wgt_ff[s1_j_ff]});
   end

   // Round half up at bit 30, then add into the running sum of this axis.
   assign rnd = (prod_ff + RND_HALF) >>> 30;
   assign term = ACC_W'(rnd);
   assign acc_in = s2_tag_ff.first ? term : (acc_ff + term);
   assign sat = (acc_in > SAT_HI) ? 32'sh7FFF_FFFF :
                (acc_in < SAT_LO) ? -32'sh8000_0000 : acc_in[31:0];
   assign done = s2_tag_ff.vld && s2_tag_ff.last && (s2_tag_ff.axis == AXIS_Z);

   always_ff @(posedge clock) begin
      if (s2_tag_ff.vld) begin
         acc_ff <= acc_in;
      end
   end

   // ------------------------------------------------------------------
   // Result registers.
   // ------------------------------------------------------------------
   assign rsp_valid_in = done || eval_bad;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (eval_bad) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         pos_z_ff <= '0;
      end else if (s2_tag_ff.vld && s2_tag_ff.last) begin
         case (s2_tag_ff.axis)
            AXIS_X: begin
               pos_x_ff <= sat;
            end
            AXIS_Y: begin
               pos_y_ff <= sat;
            end
            AXIS_Z: begin
               pos_z_ff <= sat;
            end
            default: begin
               pos_z_ff <= pos_z_ff;
            end
         endcase
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_pos_x = pos_x_ff;
   assign rsp_pos_y = pos_y_ff;
   assign rsp_pos_z = pos_z_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   `BSE_ASSERT_SAME(a_rsp_when_idle, rsp_valid_ff, state_ff == ST_IDLE, "result shown while busy")
   `BSE_ASSERT_NEXT(a_eval_starts, eval_go, busy && !rsp_valid, "evaluation did not start")
   `BSE_ASSERT_NEXT(a_write_silent, mem_we, !busy && !rsp_valid, "write produced activity")
   `BSE_ASSERT_NEXT(a_done_result, done, rsp_valid && !busy, "finished pass gave no result")
   `BSE_ASSERT_SAME(a_pipe_in_eval, s2_tag_ff.vld || wp_vld_ff, busy, "pipeline active while idle")

endmodule
